FILE: hw/rtl/csl_pkg.sv
// Shared types, sizes and codes for the cursor sequence list.
`timescale 1ns / 1ps

package csl_pkg;

  // List geometry
  localparam int LIST_DEPTH = 32;
  localparam int WORD_BITS  = 32;
  localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
  localparam int IDX_BITS   = $clog2(LIST_DEPTH);

  // Port field widths
  localparam int REQ_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 3'd0,
    REQ_ADVANCE = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_ATTACH  = 3'd3,
    REQ_REMOVE  = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_CUR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic report;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_hold;
  } dp_stat_t;

endpackage

FILE: hw/rtl/cursor_sequence_list.sv
// Top level of the cursor sequence list.
`timescale 1ns / 1ps

// An ordered list of up to 32 words with an entry count and a cursor. Each
// request item (start, advance, insert before, attach after, remove) yields
// one result item with the status, count, cursor, a current-entry flag and
// the current word. A request passes through three steps: accept, update of the
// entry registers (all entries shift in parallel), and loading of the result
// register; the controller state sequence drives these steps. The next request is
// accepted while a result waits to be taken, and a result that is not taken
// stalls the following report step. Entries are not cleared at reset; no
// entry is read before it is written.
module cursor_sequence_list (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [csl_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] entry_value
  input  logic [csl_pkg::REQ_W-1:0]         s_tuser,   // [2:0] req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [5:0] item_count, [11:6] cursor_pos, [12] has_current,
  // [44:13] current_value, [47:45] zero
  output logic [csl_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [csl_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);
  import csl_pkg::*;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [COUNT_W-1:0]  item_count;
  logic [COUNT_W-1:0]  cursor_pos;
  logic                has_current;
  logic [VALUE_W-1:0]  current_value;

  csl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csl_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (s_tuser),
    .entry_value   (s_tdata[VALUE_W-1:0]),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .status        (m_tuser),
    .item_count    (item_count),
    .cursor_pos    (cursor_pos),
    .has_current   (has_current),
    .current_value (current_value)
  );

  // Pack the result fields, lowest first
  assign m_tdata = {3'b000, current_value, has_current, cursor_pos, item_count};

endmodule

FILE: hw/rtl/csl_ctrl.sv
// Controller sequencing accept, update and report for each request.
`timescale 1ns / 1ps

module csl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  csl_pkg::dp_stat_t  stat,
  output csl_pkg::dp_cmd_t   cmd
);
  import csl_pkg::*;

  state_t state, state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (!stat.out_hold) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.report = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_REPORT: begin
        cmd.report = !stat.out_hold;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/csl_datapath.sv
// Entry registers, count, cursor and result register of the list.
`timescale 1ns / 1ps

module csl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  csl_pkg::dp_cmd_t                    cmd,
  output csl_pkg::dp_stat_t                   stat,
  input  logic [csl_pkg::REQ_W-1:0]           req_type,
  input  logic [csl_pkg::VALUE_W-1:0]         entry_value,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [csl_pkg::STATUS_W-1:0]        status,
  output logic [csl_pkg::COUNT_W-1:0]         item_count,
  output logic [csl_pkg::COUNT_W-1:0]         cursor_pos,
  output logic                                has_current,
  output logic [csl_pkg::VALUE_W-1:0]         current_value
);
  import csl_pkg::*;

  logic [REQ_W-1:0]     req_q;
  logic [WORD_BITS-1:0] word_q;
  logic [WORD_BITS-1:0] store [LIST_DEPTH];
  logic [CNT_BITS-1:0]  count, count_next;
  logic [CNT_BITS-1:0]  cursor, cursor_next;
  status_t              status_q, status_next;
  logic                 out_valid;

  logic                 cur;
  logic                 full;
  logic                 shift_up;
  logic                 shift_dn;
  logic [CNT_BITS-1:0]  pos;
  logic [CNT_BITS-1:0]  count_dec;

  assign cur       = cursor < count;
  assign full      = count == CNT_BITS'(LIST_DEPTH);
  assign count_dec = count - CNT_BITS'(1);

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      word_q <= entry_value[WORD_BITS-1:0];
    end
  end

  // Decode the request against the current count and cursor
  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    status_next = ST_DONE;
    shift_up    = 1'b0;
    shift_dn    = 1'b0;
    pos         = '0;
    case (req_q)
      REQ_START: begin
        if (count != '0) cursor_next = '0;
      end
      REQ_ADVANCE: begin
        if (!cur) status_next = ST_NO_CUR;
        else      cursor_next = cursor + CNT_BITS'(1);
      end
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          pos         = cur ? cursor : '0;
          shift_up    = 1'b1;
          cursor_next = pos;
          count_next  = count + CNT_BITS'(1);
        end
      end
      REQ_ATTACH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          pos         = cur ? cursor + CNT_BITS'(1) : count;
          shift_up    = 1'b1;
          cursor_next = pos;
          count_next  = count + CNT_BITS'(1);
        end
      end
      REQ_REMOVE: begin
        if (!cur) begin
          status_next = ST_NO_CUR;
        end else begin
          shift_dn   = 1'b1;
          count_next = count_dec;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Update count, cursor and status
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
    end else if (cmd.exec) begin
      count  <= count_next;
      cursor <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) status_q <= status_next;
  end

  // Shift every entry at once: open a gap, or close one
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_entry
    logic [WORD_BITS-1:0] below;
    logic [WORD_BITS-1:0] above;
    if (i > 0) begin : g_below
      assign below = store[i-1];
    end else begin : g_no_below
      assign below = '0;
    end
    if (i < LIST_DEPTH - 1) begin : g_above
      assign above = store[i+1];
    end else begin : g_no_above
      assign above = '0;
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (shift_up && CNT_BITS'(i) == pos) begin
          store[i] <= word_q;
        end else if (shift_up && CNT_BITS'(i) > pos && CNT_BITS'(i) <= count) begin
          store[i] <= below;
        end else if (shift_dn && CNT_BITS'(i) >= cursor && CNT_BITS'(i) < count_dec) begin
          store[i] <= above;
        end
      end
    end
  end

  // Result register: load on report, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      status      <= status_q;
      item_count  <= COUNT_W'(count);
      cursor_pos  <= COUNT_W'(cursor);
      has_current <= cur;
      current_value <= cur ? VALUE_W'(store[cursor[IDX_BITS-1:0]]) : '0;
    end
  end

  assign m_tvalid      = out_valid;
  assign stat.out_hold = out_valid && !m_tready;

endmodule
